// ----- src/twodo_pkg.sv -----
`timescale 1ns / 1ps
// shared types, constants and the cordic arctangent table for the
// two-wheel encoder odometry block; no dependencies

package twodo_pkg;

  // cordic iteration count, limited to the table length
  localparam int CORDIC_STEPS = 24;
  localparam int ATAN_ENTRIES = 30;
  localparam int CORDIC_ITERS = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
  localparam int CORDIC_CNT_W = $clog2(CORDIC_ITERS);
  localparam int ATAN_IDX_W = 5;

  // widths of the cordic datapath
  localparam int CORDIC_XY_W = 33;
  localparam int CORDIC_Z_W = 34;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WRAP_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WRAP_THRESHOLD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RAD_PER_COUNT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_METERS_PER_COUNT = 3'd4;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DELTA,
    ST_PLAN,
    ST_ROT_MUL,
    ST_ROT_ADD,
    ST_ROT_FIX,
    ST_DIST_MUL,
    ST_CORDIC_GO,
    ST_CORDIC,
    ST_X_LO,
    ST_X_HI,
    ST_X_RND,
    ST_X_ACC,
    ST_Y_LO,
    ST_Y_HI,
    ST_Y_RND,
    ST_Y_ACC,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cordic_stat_t;

  // atan(2^-i) in q30 radians
  function automatic logic [31:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
    case (idx)
      5'd0:  atan_q30 = 32'h3243F6A8;
      5'd1:  atan_q30 = 32'h1DAC6705;
      5'd2:  atan_q30 = 32'h0FADBAFC;
      5'd3:  atan_q30 = 32'h07F56EA6;
      5'd4:  atan_q30 = 32'h03FEAB76;
      5'd5:  atan_q30 = 32'h01FFD55B;
      5'd6:  atan_q30 = 32'h00FFFAAA;
      5'd7:  atan_q30 = 32'h007FFF55;
      5'd8:  atan_q30 = 32'h003FFFEA;
      5'd9:  atan_q30 = 32'h001FFFFD;
      5'd10: atan_q30 = 32'h000FFFFF;
      5'd11: atan_q30 = 32'h0007FFFF;
      5'd12: atan_q30 = 32'h0003FFFF;
      5'd13: atan_q30 = 32'h0001FFFF;
      5'd14: atan_q30 = 32'h0000FFFF;
      5'd15: atan_q30 = 32'h00007FFF;
      5'd16: atan_q30 = 32'h00003FFF;
      5'd17: atan_q30 = 32'h00001FFF;
      5'd18: atan_q30 = 32'h00000FFF;
      5'd19: atan_q30 = 32'h000007FF;
      5'd20: atan_q30 = 32'h000003FF;
      5'd21: atan_q30 = 32'h000001FF;
      5'd22: atan_q30 = 32'h000000FF;
      5'd23: atan_q30 = 32'h0000007F;
      5'd24: atan_q30 = 32'h0000003F;
      5'd25: atan_q30 = 32'h0000001F;
      5'd26: atan_q30 = 32'h0000000F;
      5'd27: atan_q30 = 32'h00000008;
      5'd28: atan_q30 = 32'h00000004;
      5'd29: atan_q30 = 32'h00000002;
      default: atan_q30 = 32'h00000000;
    endcase
  endfunction

endpackage

// ----- src/twodo_cordic.sv -----
`timescale 1ns / 1ps
// iterative rotation-mode cordic, one micro-rotation per cycle, giving
// q30 cosine and sine of a q28 heading; depends on twodo_pkg

module twodo_cordic (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      start,
  input  logic signed [31:0]                        heading,
  output twodo_pkg::cordic_stat_t                   stat,
  output logic signed [twodo_pkg::CORDIC_XY_W-1:0]  cos_q30,
  output logic signed [twodo_pkg::CORDIC_XY_W-1:0]  sin_q30
);
  import twodo_pkg::*;

  localparam logic signed [CORDIC_Z_W-1:0] PI_Q30 = 34'sd3373259426;
  localparam logic signed [CORDIC_Z_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [CORDIC_Z_W-1:0] TWO_PI_Q30 = 34'sd6746518852;
  localparam logic signed [CORDIC_XY_W-1:0] INV_GAIN = 33'sd652032874;
  localparam logic [CORDIC_CNT_W-1:0] LAST_STEP = CORDIC_CNT_W'(CORDIC_ITERS - 1);

  logic signed [CORDIC_XY_W-1:0] x, y, x_next, y_next, xs, ys;
  logic signed [CORDIC_Z_W-1:0]  z, z_next, atan_s;
  logic signed [CORDIC_Z_W-1:0]  z4, za, zb, z_init;
  logic                          flip_init, flip;
  logic [CORDIC_CNT_W-1:0]       cnt;
  logic                          busy, done;

  // range reduction into [-pi/2, pi/2]
  always_comb begin
    z4 = signed'({heading, 2'b00});
    za = (z4 > PI_Q30) ? z4 - TWO_PI_Q30 : z4;
    zb = (za < -PI_Q30) ? za + TWO_PI_Q30 : za;
    flip_init = 1'b0;
    z_init = zb;
    if (zb > HALF_PI_Q30) begin
      z_init = zb - PI_Q30;
      flip_init = 1'b1;
    end else if (zb < -HALF_PI_Q30) begin
      z_init = zb + PI_Q30;
      flip_init = 1'b1;
    end
  end

  // one micro-rotation
  always_comb begin
    xs = x >>> cnt;
    ys = y >>> cnt;
    atan_s = signed'({2'b00, atan_q30(ATAN_IDX_W'(cnt))});
    if (!z[CORDIC_Z_W-1]) begin
      x_next = x - ys;
      y_next = y + xs;
      z_next = z - atan_s;
    end else begin
      x_next = x + ys;
      y_next = y - xs;
      z_next = z + atan_s;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x    <= INV_GAIN;
      y    <= '0;
      z    <= z_init;
      flip <= flip_init;
    end else if (busy) begin
      x <= x_next;
      y <= y_next;
      z <= z_next;
      if (cnt == LAST_STEP) begin
        cos_q30 <= flip ? -x_next : x_next;
        sin_q30 <= flip ? -y_next : y_next;
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ----- src/two_wheel_encoder_odometry_unit.sv -----
`timescale 1ns / 1ps
// top level of the two-wheel encoder odometry block: sequencer, shared
// 32x32 multiplier and pose registers; depends on twodo_pkg and twodo_cordic

// One request is taken at a time; s_tready is high only while the sequencer
// waits for work. The first request after reset goes straight to the result,
// one inside the dead band returns to idle with no result, a turn runs the
// rotation multiply, add and fix states, and a straight move runs the cordic
// that does one micro-rotation a cycle and makes five passes through the one
// shared multiplier. A result waits in the output register while the next
// request is taken; only a second result stalls on it.

module two_wheel_encoder_odometry_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [31:0]   s_tdata,   // left_count[14:0], right_count[29:15], zero fill
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [127:0]  m_tdata,   // pose_x[47:0], pose_y[95:48], pose_heading[127:96]
  input  logic          cfg_we,
  input  logic [twodo_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [23:0]   cfg_data
);
  import twodo_pkg::*;

  localparam logic signed [43:0] TWO_PI_Q28 = 44'sd1686629713;
  localparam logic signed [43:0] HEAD_MAX = 44'sd2147483647;
  localparam logic signed [43:0] HEAD_MIN = -44'sd2147483648;
  localparam logic signed [49:0] POS_MAX = 50'sd140737488355327;
  localparam logic signed [49:0] POS_MIN = -50'sd140737488355328;
  localparam logic [71:0] ROUND_HALF = 72'd536870912;

  state_t state, state_next;

  logic [14:0] deadband_counts, wrap_count, wrap_threshold;
  logic [23:0] rad_per_count, meters_per_count;

  logic [14:0] prev_left, prev_right, cur_left, cur_right;
  logic        have_first;
  logic signed [47:0] pos_x, pos_y;
  logic signed [31:0] heading;

  logic signed [16:0] ud1, ud2;
  logic [15:0] m_mag;
  logic [16:0] sum_mag;
  logic        rot_neg, dist_neg;
  logic [39:0] dist_mag;
  logic signed [43:0] head_sum;
  logic [63:0] prod, plo;
  logic [41:0] rnd;

  logic [31:0] mul_a, mul_b;
  logic        cordic_start, out_load;
  cordic_stat_t cordic_stat;
  logic signed [CORDIC_XY_W-1:0] cos_q30, sin_q30;

  logic signed [16:0] raw_d1, raw_d2, unw_d1, unw_d2;
  logic        in_deadband, same_sign;
  logic signed [17:0] dsum;
  logic [16:0] mag_u1, mag_u2;
  logic [31:0] c_mag, s_mag;
  logic        acc_neg;
  logic [71:0] wide_sum;
  logic signed [49:0] acc_delta, acc_sum, acc_sat;
  logic signed [47:0] acc_base;
  logic signed [43:0] head_fix, head_term;

  function automatic logic [16:0] mag17(input logic signed [16:0] v);
    mag17 = v[16] ? unsigned'(-v) : unsigned'(v);
  endfunction

  function automatic logic signed [16:0] unwrap(input logic signed [16:0] d,
                                                input logic [14:0] thr,
                                                input logic [14:0] wrap);
    logic signed [16:0] ts, ws, t;
    ts = signed'({2'b00, thr});
    ws = signed'({2'b00, wrap});
    t = (d > ts) ? d - ws : d;
    unwrap = (t < -ts) ? t + ws : t;
  endfunction

  twodo_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cordic_start),
    .heading (heading),
    .stat    (cordic_stat),
    .cos_q30 (cos_q30),
    .sin_q30 (sin_q30)
  );

  // delta, dead band and wraparound
  always_comb begin
    raw_d1 = signed'({2'b00, cur_left}) - signed'({2'b00, prev_left});
    raw_d2 = signed'({2'b00, cur_right}) - signed'({2'b00, prev_right});
    in_deadband = (mag17(raw_d1) < {2'b00, deadband_counts}) &&
                  (mag17(raw_d2) < {2'b00, deadband_counts});
    unw_d1 = unwrap(raw_d1, wrap_threshold, wrap_count);
    unw_d2 = unwrap(raw_d2, wrap_threshold, wrap_count);
    same_sign = (!ud1[16] && !ud2[16]) ||
                ((ud1[16] || ud1 == '0) && (ud2[16] || ud2 == '0));
    dsum = 18'(ud1) + 18'(ud2);
    mag_u1 = mag17(ud1);
    mag_u2 = mag17(ud2);
  end

  // cordic result magnitudes and signs
  always_comb begin
    c_mag = cos_q30[CORDIC_XY_W-1] ? 32'(-cos_q30) : 32'(cos_q30);
    s_mag = sin_q30[CORDIC_XY_W-1] ? 32'(-sin_q30) : 32'(sin_q30);
  end

  // rounding and accumulation of one position component
  always_comb begin
    wide_sum = {prod[39:0], 32'b0} + {8'b0, plo} + ROUND_HALF;
    acc_neg = (state == ST_X_ACC) ? (dist_neg ^ cos_q30[CORDIC_XY_W-1])
                                  : (dist_neg ^ sin_q30[CORDIC_XY_W-1]);
    acc_base = (state == ST_X_ACC) ? pos_x : pos_y;
    acc_delta = acc_neg ? -signed'({8'b0, rnd}) : signed'({8'b0, rnd});
    acc_sum = 50'(acc_base) + acc_delta;
    if (acc_sum > POS_MAX) acc_sat = POS_MAX;
    else if (acc_sum < POS_MIN) acc_sat = POS_MIN;
    else acc_sat = acc_sum;
  end

  // heading update
  always_comb begin
    head_term = rot_neg ? -signed'({3'b0, prod[40:0]}) : signed'({3'b0, prod[40:0]});
    head_fix = head_sum;
    if (head_sum > TWO_PI_Q28) head_fix = head_sum - TWO_PI_Q28;
    else if (head_sum < -TWO_PI_Q28) head_fix = head_sum + TWO_PI_Q28;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (s_tvalid) state_next = ST_DELTA;
      ST_DELTA: begin
        if (!have_first) state_next = ST_EMIT;
        else if (in_deadband) state_next = ST_IDLE;
        else state_next = ST_PLAN;
      end
      ST_PLAN:      state_next = same_sign ? ST_ROT_MUL : ST_DIST_MUL;
      ST_ROT_MUL:   state_next = ST_ROT_ADD;
      ST_ROT_ADD:   state_next = ST_ROT_FIX;
      ST_ROT_FIX:   state_next = ST_EMIT;
      ST_DIST_MUL:  state_next = ST_CORDIC_GO;
      ST_CORDIC_GO: state_next = ST_CORDIC;
      ST_CORDIC:    if (cordic_stat.done) state_next = ST_X_LO;
      ST_X_LO:      state_next = ST_X_HI;
      ST_X_HI:      state_next = ST_X_RND;
      ST_X_RND:     state_next = ST_X_ACC;
      ST_X_ACC:     state_next = ST_Y_LO;
      ST_Y_LO:      state_next = ST_Y_HI;
      ST_Y_HI:      state_next = ST_Y_RND;
      ST_Y_RND:     state_next = ST_Y_ACC;
      ST_Y_ACC:     state_next = ST_EMIT;
      ST_EMIT:      if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs and multiplier operands
  always_comb begin
    s_tready = 1'b0;
    cordic_start = 1'b0;
    out_load = 1'b0;
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_IDLE:      s_tready = 1'b1;
      ST_ROT_MUL: begin
        mul_a = {8'b0, rad_per_count};
        mul_b = {15'b0, sum_mag};
      end
      ST_DIST_MUL: begin
        mul_a = {16'b0, m_mag};
        mul_b = {8'b0, meters_per_count};
      end
      ST_CORDIC_GO: cordic_start = 1'b1;
      ST_X_LO: begin
        mul_a = dist_mag[31:0];
        mul_b = c_mag;
      end
      ST_X_HI: begin
        mul_a = {24'b0, dist_mag[39:32]};
        mul_b = c_mag;
      end
      ST_Y_LO: begin
        mul_a = dist_mag[31:0];
        mul_b = s_mag;
      end
      ST_Y_HI: begin
        mul_a = {24'b0, dist_mag[39:32]};
        mul_b = s_mag;
      end
      ST_EMIT:      out_load = !m_tvalid || m_tready;
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  // shared multiplier, registered product
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // control state, configuration and pose
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      deadband_counts  <= 15'd5;
      wrap_count       <= 15'd32767;
      wrap_threshold   <= 15'd26213;
      rad_per_count    <= 24'd702762;
      meters_per_count <= 24'd1917396;
      prev_left        <= '0;
      prev_right       <= '0;
      have_first       <= 1'b0;
      pos_x            <= '0;
      pos_y            <= '0;
      heading          <= '0;
      m_tvalid         <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_DEADBAND:         deadband_counts  <= cfg_data[14:0];
          REG_WRAP_COUNT:       wrap_count       <= cfg_data[14:0];
          REG_WRAP_THRESHOLD:   wrap_threshold   <= cfg_data[14:0];
          REG_RAD_PER_COUNT:    rad_per_count    <= cfg_data;
          REG_METERS_PER_COUNT: meters_per_count <= cfg_data;
          default: begin
          end
        endcase
      end
      if (state == ST_DELTA && (!have_first || !in_deadband)) begin
        prev_left  <= cur_left;
        prev_right <= cur_right;
      end
      if (state == ST_DELTA && !have_first) begin
        have_first <= 1'b1;
        pos_x      <= '0;
        pos_y      <= '0;
        heading    <= '0;
      end
      if (state == ST_ROT_FIX) begin
        if (head_fix > HEAD_MAX) heading <= 32'(HEAD_MAX);
        else if (head_fix < HEAD_MIN) heading <= 32'(HEAD_MIN);
        else heading <= 32'(head_fix);
      end
      if (state == ST_X_ACC) pos_x <= 48'(acc_sat);
      if (state == ST_Y_ACC) pos_y <= 48'(acc_sat);
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cur_left  <= s_tdata[14:0];
      cur_right <= s_tdata[29:15];
    end
    if (state == ST_DELTA) begin
      ud1 <= unw_d1;
      ud2 <= unw_d2;
    end
    if (state == ST_PLAN) begin
      sum_mag  <= dsum[17] ? 17'(-dsum) : 17'(dsum);
      rot_neg  <= dsum[17];
      m_mag    <= (mag_u1 < mag_u2) ? mag_u1[15:0] : mag_u2[15:0];
      dist_neg <= ud2[16] || ud2 == '0;
    end
    if (state == ST_ROT_ADD) head_sum <= 44'(heading) + head_term;
    if (state == ST_CORDIC_GO) dist_mag <= prod[39:0];
    if (state == ST_X_HI || state == ST_Y_HI) plo <= prod;
    if (state == ST_X_RND || state == ST_Y_RND) rnd <= wide_sum[71:30];
    if (out_load) m_tdata <= {heading, pos_y, pos_x};
  end

  // checks
  assert property (@(posedge clk) disable iff (rst) s_tready |-> !cordic_stat.busy)
    else $error("request taken while cordic busy");

  assert property (@(posedge clk) disable iff (rst) cordic_stat.done |-> state == ST_CORDIC)
    else $error("cordic finished outside its wait state");

  assert property (@(posedge clk) disable iff (rst) out_load |=> m_tvalid)
    else $error("result load lost");

  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !out_load)
    else $error("pending result overwritten");

endmodule

// ----- tb/sv/two_wheel_encoder_odometry_unit_test.sv -----
`timescale 1ns / 1ps
// self-checking testbench for two_wheel_encoder_odometry_unit: streams encoder count pairs,
// predicts each pose in fixed point and compares it with the block's output stream
// depends on twodo_pkg and the rtl of the block

module two_wheel_encoder_odometry_unit_test;
  import twodo_pkg::*;

  typedef struct packed {
    logic [47:0] x;
    logic [47:0] y;
    logic [31:0] hdg;
  } pose_t;

  localparam longint TWO_PI_Q28 = 64'sd1686629713;
  localparam longint PI_Q30 = 64'sd3373259426;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint TWO_PI_Q30 = 64'sd6746518852;
  localparam longint INV_GAIN_Q30 = 64'sd652032874;
  localparam longint POS_MAX = 64'sd140737488355327;
  localparam longint POS_MIN = -64'sd140737488355328;
  localparam longint HDG_MAX = 64'sd2147483647;
  localparam longint HDG_MIN = -64'sd2147483648;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 50;
  localparam int STALL_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [31:0] s_tdata;   // left_count[14:0], right_count[29:15], zero fill
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [127:0] m_tdata;  // pose_x[47:0], pose_y[95:48], pose_heading[127:96]
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [23:0] cfg_data;

  // own copy of configuration and pose state
  longint deadband_cfg = 5;
  longint wrap_cfg = 32767;
  longint thresh_cfg = 26213;
  longint rad_cfg = 702762;
  longint mpc_cfg = 1917396;
  longint prev_l = 0;
  longint prev_r = 0;
  bit started = 1'b0;
  longint pos_x_q32 = 0;
  longint pos_y_q32 = 0;
  longint heading_q28 = 0;

  longint arctan_q30 [30] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
    64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
    64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
    64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002
  };

  pose_t expected_poses [$];
  logic [14:0] cur_l = '0;
  logic [14:0] cur_r = '0;
  int send_idle_pct;
  int recv_idle_pct;
  logic hold_req;
  int hold_cnt = 0;
  int stall_cycles = 0;
  int fail_count = 0;

  two_wheel_encoder_odometry_unit i_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint mag(input longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint unwrap_delta(input longint d);
    longint v;
    v = d;
    if (v > thresh_cfg) v -= wrap_cfg;
    if (v < -thresh_cfg) v += wrap_cfg;
    return v;
  endfunction

  // product scaled by 2^-30, half away from zero
  function automatic longint scale_q30(input longint a, input longint b);
    logic [63:0] ma;
    logic [63:0] mb;
    logic [127:0] prod;
    longint r;
    ma = mag(a);
    mb = mag(b);
    prod = ({64'd0, ma} * {64'd0, mb} + 128'h2000_0000) >> 30;
    r = prod[63:0];
    return ((a < 0) != (b < 0)) ? -r : r;
  endfunction

  function automatic void cordic_sincos(input longint angle_q28, output longint c,
                                        output longint s);
    longint z;
    longint x;
    longint y;
    longint t;
    bit flip;
    int i;
    z = angle_q28 * 4;
    x = INV_GAIN_Q30;
    y = 0;
    flip = 1'b0;
    if (z > PI_Q30) z -= TWO_PI_Q30;
    if (z < -PI_Q30) z += TWO_PI_Q30;
    if (z > HALF_PI_Q30) begin
      z -= PI_Q30;
      flip = 1'b1;
    end else if (z < -HALF_PI_Q30) begin
      z += PI_Q30;
      flip = 1'b1;
    end
    for (i = 0; i < CORDIC_ITERS; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        z -= arctan_q30[i];
      end else begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        z += arctan_q30[i];
      end
      x = t;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic void predict_pose(input logic [14:0] l, input logic [14:0] r);
    longint ln;
    longint rn;
    longint d1;
    longint d2;
    longint t;
    longint m;
    longint travel;
    longint c;
    longint s;
    pose_t p;
    ln = l;
    rn = r;
    if (!started) begin
      started = 1'b1;
      pos_x_q32 = 0;
      pos_y_q32 = 0;
      heading_q28 = 0;
    end else begin
      d1 = ln - prev_l;
      d2 = rn - prev_r;
      if (mag(d1) < deadband_cfg && mag(d2) < deadband_cfg) return;
      d1 = unwrap_delta(d1);
      d2 = unwrap_delta(d2);
      if ((d1 >= 0 && d2 >= 0) || (d1 <= 0 && d2 <= 0)) begin
        t = heading_q28 + rad_cfg * (d1 + d2);
        if (t > TWO_PI_Q28) t -= TWO_PI_Q28;
        if (t < -TWO_PI_Q28) t += TWO_PI_Q28;
        heading_q28 = clamp(t, HDG_MIN, HDG_MAX);
      end else begin
        m = mag(d1) < mag(d2) ? d1 : d2;
        travel = mag(m) * mpc_cfg;
        if (d2 <= 0) travel = -travel;
        cordic_sincos(heading_q28, c, s);
        pos_x_q32 = clamp(pos_x_q32 + scale_q30(travel, c), POS_MIN, POS_MAX);
        pos_y_q32 = clamp(pos_y_q32 + scale_q30(travel, s), POS_MIN, POS_MAX);
      end
    end
    prev_l = ln;
    prev_r = rn;
    p.x = pos_x_q32[47:0];
    p.y = pos_y_q32[47:0];
    p.hdg = heading_q28[31:0];
    expected_poses.push_back(p);
  endfunction

  task automatic send_counts(input logic [14:0] l, input logic [14:0] r);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {2'b00, r, l};
    do @(posedge clk); while (!s_tready);
    predict_pose(l, r);
  endtask

  task automatic set_counts(input logic [14:0] l, input logic [14:0] r);
    cur_l = l;
    cur_r = r;
    send_counts(cur_l, cur_r);
  endtask

  task automatic move(input int dl, input int dr);
    cur_l = 15'(cur_l + dl);
    cur_r = 15'(cur_r + dr);
    send_counts(cur_l, cur_r);
  endtask

  // no request in flight and no pose outstanding
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (expected_poses.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_DEADBAND: deadband_cfg = data[14:0];
      REG_WRAP_COUNT: wrap_cfg = data[14:0];
      REG_WRAP_THRESHOLD: thresh_cfg = data[14:0];
      REG_RAD_PER_COUNT: rad_cfg = data;
      REG_METERS_PER_COUNT: mpc_cfg = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic random_item();
    int pick;
    int a;
    int b;
    pick = $urandom_range(99);
    a = $urandom_range(1) ? $urandom_range(40) : $urandom_range(3000);
    b = $urandom_range(1) ? $urandom_range(40) : $urandom_range(3000);
    if (pick < 10) begin
      set_counts(15'($urandom), 15'($urandom));
    end else if (pick < 25) begin
      move(int'($urandom_range(12)) - 6, int'($urandom_range(12)) - 6);
    end else if (pick < 50) begin
      if ($urandom_range(1)) move(a, b);
      else move(-a, -b);
    end else if (pick < 90) begin
      if ($urandom_range(1)) move(-a, b);
      else move(a, -b);
    end else begin
      move($urandom_range(32767), $urandom_range(32767));
    end
  endtask

  task automatic run_random(input int n);
    repeat (n) random_item();
  endtask

  task automatic test_directed();
    set_counts(100, 200);
    set_counts(102, 203);
    set_counts(104, 196);
    set_counts(105, 200);
    set_counts(95, 210);
    set_counts(100, 205);
    set_counts(90, 245);
    set_counts(100, 240);
    set_counts(15'h7FFF, 0);
    set_counts(0, 15'h7FFF);
    set_counts(0, 0);
    set_counts(20000, 20000);
    set_counts(200, 200);
    set_counts(300, 100);
    set_counts(15'h7FFF, 15'h7FFF);
    set_counts(15'h2AAA, 15'h5555);
    set_counts(15'h5555, 15'h2AAA);
  endtask

  task automatic test_config_extremes();
    int k;
    wait_idle();
    write_reg(REG_DEADBAND, 0);
    move(0, 0);
    move(1, -1);
    set_counts(0, 0);
    run_random(6);
    set_counts(0, 0);
    wait_idle();
    write_reg(REG_DEADBAND, 24'h007FFF);
    set_counts(15'h7FFF, 0);
    set_counts(0, 15'h7FFF);
    run_random(4);
    wait_idle();
    write_reg(REG_DEADBAND, 3);
    write_reg(REG_WRAP_COUNT, 0);
    write_reg(REG_WRAP_THRESHOLD, 0);
    run_random(6);
    wait_idle();
    write_reg(REG_WRAP_COUNT, 1);
    write_reg(REG_WRAP_THRESHOLD, 24'h007FFF);
    run_random(6);
    wait_idle();
    write_reg(REG_WRAP_COUNT, 20);
    write_reg(REG_WRAP_THRESHOLD, 8);
    move(30, -12);
    move(-9, 40);
    run_random(4);
    wait_idle();
    write_reg(REG_RAD_PER_COUNT, 0);
    write_reg(REG_METERS_PER_COUNT, 0);
    run_random(6);
    wait_idle();
    write_reg(REG_RAD_PER_COUNT, 24'hFFFFFF);
    write_reg(REG_METERS_PER_COUNT, 24'hFFFFFF);
    write_reg(REG_WRAP_COUNT, 24'hFFFFFF);
    write_reg(REG_WRAP_THRESHOLD, 26213);
    run_random(6);
    wait_idle();
    // unused indexes must leave every register alone
    for (k = REG_METERS_PER_COUNT + 1; k < 2 ** CFG_IDX_W; k++) begin
      write_reg(CFG_IDX_W'(k), 24'($urandom));
    end
    write_reg(REG_DEADBAND, 24'hFF8004);
    run_random(6);
  endtask

  task automatic test_backpressure();
    wait_idle();
    write_reg(REG_DEADBAND, 5);
    write_reg(REG_WRAP_THRESHOLD, 26213);
    write_reg(REG_RAD_PER_COUNT, 702762);
    write_reg(REG_METERS_PER_COUNT, 1917396);
    hold_req <= 1'b1;
    repeat (10) move(-400, int'($urandom_range(300, 500)));
    hold_req <= 1'b0;
    wait_idle();
  endtask

  task automatic test_random();
    int blk;
    for (blk = 0; blk < 4; blk++) begin
      wait_idle();
      if (blk == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_reg(REG_DEADBAND, 24'($urandom_range(12)));
      write_reg(REG_WRAP_COUNT,
                24'($urandom_range(3) == 0 ? $urandom_range(32767) : 32767));
      write_reg(REG_WRAP_THRESHOLD, 24'($urandom_range(16000, 32767)));
      write_reg(REG_RAD_PER_COUNT, 24'($urandom_range(24'hFFFFFF)));
      write_reg(REG_METERS_PER_COUNT, 24'($urandom));
      run_random(80);
    end
  endtask

  always @(posedge clk) begin
    if (hold_req && hold_cnt < HOLD_CYCLES) begin
      m_tready <= 1'b0;
      hold_cnt <= hold_cnt + 1;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
      if (!hold_req) hold_cnt <= 0;
    end
  end

  always @(posedge clk) begin
    pose_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_poses.size() == 0) begin
        $error("pose with none expected: x %0d y %0d heading %0d", $signed(m_tdata[47:0]),
               $signed(m_tdata[95:48]), $signed(m_tdata[127:96]));
        fail_count++;
      end else begin
        want = expected_poses.pop_front();
        if (m_tdata[47:0] !== want.x) begin
          $error("pose_x expected %0d got %0d", $signed(want.x), $signed(m_tdata[47:0]));
          fail_count++;
        end
        if (m_tdata[95:48] !== want.y) begin
          $error("pose_y expected %0d got %0d", $signed(want.y), $signed(m_tdata[95:48]));
          fail_count++;
        end
        if (m_tdata[127:96] !== want.hdg) begin
          $error("pose_heading expected %0d got %0d", $signed(want.hdg),
                 $signed(m_tdata[127:96]));
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $error("nothing moved for %0d cycles", STALL_LIMIT);
      $display("two_wheel_encoder_odometry_unit_test: done, errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    cfg_we <= 1'b0;
    cfg_index <= REG_DEADBAND;
    cfg_data <= '0;
    hold_req <= 1'b0;
    send_idle_pct = 37;
    recv_idle_pct = 45;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_config_extremes();
    wait_idle();
    send_idle_pct = 45;
    recv_idle_pct = 37;
    test_backpressure();
    test_random();
    wait_idle();
    if (fail_count == 0 && expected_poses.size() == 0) begin
      $display("two_wheel_encoder_odometry_unit_test: done, clean");
    end else begin
      $display("two_wheel_encoder_odometry_unit_test: done, errors");
    end
    $finish;
  end

endmodule
